FILE: rtl/core/nsp_pkg.sv
// shared types and constants for the nearest segment path ordering block
`default_nettype none

package nsp_pkg;

    localparam int DEF_TABLE_DEPTH = 4096;
    localparam int DEF_COORD_BITS  = 24;

    localparam int FIELD_COORD_W = 24;
    localparam int FIELD_INDEX_W = 12;
    localparam int S_TDATA_W     = 152;
    localparam int M_TDATA_W     = 112;

    typedef enum logic [1:0] {
        ACT_LOAD  = 2'd0,
        ACT_CLEAR = 2'd1,
        ACT_START = 2'd2,
        ACT_NEXT  = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        STAT_ACCEPTED = 2'd0,
        STAT_FULL     = 2'd1,
        STAT_GIVEN    = 2'd2,
        STAT_NONE     = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_SCAN,
        S_FETCH,
        S_FETCH_WAIT,
        S_DONE
    } state_t;

    typedef struct packed {
        logic go;
        logic force_first;
    } scan_cmd_t;

    typedef struct packed {
        logic done;
        logic found;
        logic flip;
    } scan_stat_t;

endpackage

`default_nettype wire

FILE: rtl/core/nearest_segment_path_ordering_top.sv
// top level: item handshakes, control sequencer, table and mark memories
// next item: one entry read per cycle through the distance pipeline, then a fetch of the chosen entry
// start item: a sweep of the mark memory, one entry per cycle
// load and clear items return a status; results leave through a registered output stage
// after reset the whole mark memory is swept with s_tready low
// reset empties the table, zeroes the position and clears the forced first pick
`default_nettype none

module nearest_segment_path_ordering_top
    import nsp_pkg::*;
#(
    parameter int TABLE_DEPTH = DEF_TABLE_DEPTH,
    parameter int COORD_BITS  = DEF_COORD_BITS
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    // seg_x1, seg_y1, seg_x2, seg_y2, pos_x, pos_y, start_at_first, zero fill
    input  wire logic [S_TDATA_W-1:0]  s_tdata,
    // action
    input  wire logic [1:0]            s_tuser,
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    // seg_index, from_x, from_y, to_x, to_y, jump, zero fill
    output logic      [M_TDATA_W-1:0]  m_tdata,
    // status
    output logic      [1:0]            m_tuser
);
    localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
    localparam int C     = COORD_BITS;
    localparam int W     = FIELD_COORD_W;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(TABLE_DEPTH);

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] count_reg;
    logic [C-1:0]     cur_x_reg, cur_y_reg;
    logic             force_reg;
    logic [IDX_W-1:0] clr_ptr_reg;
    logic             clr_start_reg;

    status_t          res_status_reg;
    logic [FIELD_INDEX_W-1:0] res_idx_reg;
    logic [W-1:0]     res_fx_reg, res_fy_reg, res_tx_reg, res_ty_reg;
    logic             res_jump_reg;

    logic             m_valid_reg;
    status_t          m_status_reg;
    logic [FIELD_INDEX_W-1:0] m_idx_reg;
    logic [W-1:0]     m_fx_reg, m_fy_reg, m_tx_reg, m_ty_reg;
    logic             m_jump_reg;

    logic             accept;
    action_t          action;
    logic [W-1:0]     in_x1, in_y1, in_x2, in_y2, in_px, in_py;
    logic             in_first;
    logic             table_full;
    logic             out_free;

    logic             seg_we, seg_re;
    logic [IDX_W-1:0] seg_raddr;
    logic [4*C-1:0]   seg_wdata, seg_rdata;
    logic             mark_we, mark_wdata, mark_rdata;
    logic [IDX_W-1:0] mark_waddr;

    scan_cmd_t        scan_cmd;
    scan_stat_t       scan_stat;
    logic             scan_issue;
    logic [IDX_W-1:0] scan_addr;
    logic [IDX_W-1:0] best_idx;

    logic [C-1:0]     ax, ay, bx, by, fx, fy, tx, ty;

    assign action   = action_t'(s_tuser);
    assign in_x1    = s_tdata[W-1:0];
    assign in_y1    = s_tdata[2*W-1:W];
    assign in_x2    = s_tdata[3*W-1:2*W];
    assign in_y2    = s_tdata[4*W-1:3*W];
    assign in_px    = s_tdata[5*W-1:4*W];
    assign in_py    = s_tdata[6*W-1:5*W];
    assign in_first = s_tdata[6*W];

    assign accept     = s_tvalid && s_tready;
    assign table_full = count_reg >= FULL_CNT;
    assign out_free   = !m_valid_reg || m_tready;

    assign ax = seg_rdata[C-1:0];
    assign ay = seg_rdata[2*C-1:C];
    assign bx = seg_rdata[3*C-1:2*C];
    assign by = seg_rdata[4*C-1:3*C];
    assign fx = scan_stat.flip ? bx : ax;
    assign fy = scan_stat.flip ? by : ay;
    assign tx = scan_stat.flip ? ax : bx;
    assign ty = scan_stat.flip ? ay : by;

    assign seg_wdata = {C'(in_y2), C'(in_x2), C'(in_y1), C'(in_x1)};

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_CLEAR: begin
                if (clr_ptr_reg == LAST_IDX) begin
                    state_next = clr_start_reg ? S_DONE : S_IDLE;
                end
            end
            S_IDLE: begin
                if (accept) begin
                    case (action)
                        ACT_NEXT:  state_next = S_SCAN;
                        ACT_START: state_next = S_CLEAR;
                        default:   state_next = S_DONE;
                    endcase
                end
            end
            S_SCAN: begin
                if (scan_stat.done) begin
                    state_next = scan_stat.found ? S_FETCH : S_DONE;
                end
            end
            S_FETCH:      state_next = S_FETCH_WAIT;
            S_FETCH_WAIT: state_next = S_DONE;
            S_DONE: begin
                if (out_free) begin
                    state_next = S_IDLE;
                end
            end
            default:      state_next = S_CLEAR;
        endcase
    end

    // control outputs
    always_comb begin
        s_tready             = 1'b0;
        seg_we               = 1'b0;
        seg_re               = scan_issue;
        seg_raddr            = scan_addr;
        mark_we              = 1'b0;
        mark_waddr           = clr_ptr_reg;
        mark_wdata           = 1'b0;
        scan_cmd.go          = 1'b0;
        scan_cmd.force_first = force_reg;
        case (state_reg)
            S_CLEAR: begin
                mark_we = 1'b1;
            end
            S_IDLE: begin
                s_tready    = 1'b1;
                seg_we      = s_tvalid && (action == ACT_LOAD) && !table_full;
                scan_cmd.go = s_tvalid && (action == ACT_NEXT);
            end
            S_FETCH: begin
                seg_re     = 1'b1;
                seg_raddr  = best_idx;
                mark_we    = 1'b1;
                mark_waddr = best_idx;
                mark_wdata = 1'b1;
            end
            default: begin
                s_tready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_CLEAR;
            count_reg     <= '0;
            cur_x_reg     <= '0;
            cur_y_reg     <= '0;
            force_reg     <= 1'b0;
            clr_ptr_reg   <= '0;
            clr_start_reg <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (state_reg == S_CLEAR) begin
                clr_ptr_reg <= clr_ptr_reg + IDX_W'(1);
            end
            if (accept) begin
                case (action)
                    ACT_LOAD: begin
                        if (!table_full) begin
                            count_reg <= count_reg + CNT_W'(1);
                        end
                    end
                    ACT_CLEAR: begin
                        count_reg <= '0;
                    end
                    ACT_START: begin
                        cur_x_reg     <= C'(in_px);
                        cur_y_reg     <= C'(in_py);
                        force_reg     <= in_first;
                        clr_ptr_reg   <= '0;
                        clr_start_reg <= 1'b1;
                    end
                    default: begin
                        clr_start_reg <= clr_start_reg;
                    end
                endcase
            end
            if (state_reg == S_FETCH_WAIT) begin
                cur_x_reg <= tx;
                cur_y_reg <= ty;
                force_reg <= 1'b0;
            end
            if (state_reg == S_DONE && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // result payload
    always_ff @(posedge aclk) begin
        if (state_reg == S_IDLE && accept) begin
            res_status_reg <= (action == ACT_LOAD && table_full) ? STAT_FULL : STAT_ACCEPTED;
            res_idx_reg    <= '0;
            res_fx_reg     <= '0;
            res_fy_reg     <= '0;
            res_tx_reg     <= '0;
            res_ty_reg     <= '0;
            res_jump_reg   <= 1'b0;
        end
        if (state_reg == S_SCAN && scan_stat.done) begin
            res_status_reg <= STAT_NONE;
        end
        if (state_reg == S_FETCH_WAIT) begin
            res_status_reg <= STAT_GIVEN;
            res_idx_reg    <= FIELD_INDEX_W'(best_idx);
            res_fx_reg     <= W'(fx);
            res_fy_reg     <= W'(fy);
            res_tx_reg     <= W'(tx);
            res_ty_reg     <= W'(ty);
            res_jump_reg   <= (fx != cur_x_reg) || (fy != cur_y_reg);
        end
        if (state_reg == S_DONE && out_free) begin
            m_status_reg <= res_status_reg;
            m_idx_reg    <= res_idx_reg;
            m_fx_reg     <= res_fx_reg;
            m_fy_reg     <= res_fy_reg;
            m_tx_reg     <= res_tx_reg;
            m_ty_reg     <= res_ty_reg;
            m_jump_reg   <= res_jump_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_status_reg;
    assign m_tdata  = {3'b000, m_jump_reg, m_ty_reg, m_tx_reg, m_fy_reg, m_fx_reg, m_idx_reg};

    nsp_seg_store #(
        .DEPTH (TABLE_DEPTH),
        .WIDTH (4 * COORD_BITS)
    ) u_seg_store (
        .aclk  (aclk),
        .we    (seg_we),
        .waddr (count_reg[IDX_W-1:0]),
        .wdata (seg_wdata),
        .re    (seg_re),
        .raddr (seg_raddr),
        .rdata (seg_rdata)
    );

    nsp_mark_store #(
        .DEPTH (TABLE_DEPTH)
    ) u_mark_store (
        .aclk  (aclk),
        .we    (mark_we),
        .waddr (mark_waddr),
        .wdata (mark_wdata),
        .re    (scan_issue),
        .raddr (scan_addr),
        .rdata (mark_rdata)
    );

    nsp_scan #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .COORD_BITS  (COORD_BITS)
    ) u_scan (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (scan_cmd),
        .count    (count_reg),
        .cur_x    (cur_x_reg),
        .cur_y    (cur_y_reg),
        .rd_data  (seg_rdata),
        .rd_mark  (mark_rdata),
        .rd_issue (scan_issue),
        .rd_addr  (scan_addr),
        .stat     (scan_stat),
        .best_idx (best_idx)
    );

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= FULL_CNT)
        else $error("segment count beyond table depth");

    a_done_in_scan: assert property (@(posedge aclk) disable iff (!aresetn)
        scan_stat.done |-> (state_reg == S_SCAN))
        else $error("scan finished outside a next item");

    a_best_in_table: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_FETCH) |-> (CNT_W'(best_idx) < count_reg))
        else $error("chosen segment lies beyond the loaded table");

    a_scan_no_mark_write: assert property (@(posedge aclk) disable iff (!aresetn)
        scan_issue |-> !mark_we)
        else $error("mark written while the scan reads it");

endmodule

`default_nettype wire

FILE: rtl/core/nsp_seg_store.sv
// segment table memory, one write port and one registered read port
`default_nettype none

module nsp_seg_store
    import nsp_pkg::*;
#(
    parameter int DEPTH = DEF_TABLE_DEPTH,
    parameter int WIDTH = 4 * DEF_COORD_BITS,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [ADDR_W-1:0]        waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [ADDR_W-1:0]        raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/nsp_mark_store.sv
// visited mark memory, one write port and one registered read port
`default_nettype none

module nsp_mark_store
    import nsp_pkg::*;
#(
    parameter int DEPTH = DEF_TABLE_DEPTH,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic                  aclk,
    input  wire logic                  we,
    input  wire logic [ADDR_W-1:0]     waddr,
    input  wire logic                  wdata,
    input  wire logic                  re,
    input  wire logic [ADDR_W-1:0]     raddr,
    output logic                       rdata
);
    logic mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/nsp_scan.sv
// table scan: distance pipeline over stored segments and nearest selection
`default_nettype none

module nsp_scan
    import nsp_pkg::*;
#(
    parameter int TABLE_DEPTH = DEF_TABLE_DEPTH,
    parameter int COORD_BITS  = DEF_COORD_BITS,
    localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1,
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1)
) (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire scan_cmd_t                  cmd,
    input  wire logic [CNT_W-1:0]           count,
    input  wire logic [COORD_BITS-1:0]      cur_x,
    input  wire logic [COORD_BITS-1:0]      cur_y,
    input  wire logic [4*COORD_BITS-1:0]    rd_data,
    input  wire logic                       rd_mark,
    output logic                            rd_issue,
    output logic      [IDX_W-1:0]           rd_addr,
    output scan_stat_t                      stat,
    output logic      [IDX_W-1:0]           best_idx
);
    localparam int C     = COORD_BITS;
    localparam int SQ_W  = 2 * C;
    localparam int D_W   = 2 * C + 1;

    logic             running_reg, running_next;
    logic [CNT_W-1:0] ptr_reg;
    logic             force_reg;

    logic             v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;
    logic [IDX_W-1:0] idx1_reg, idx2_reg, idx3_reg, idx4_reg, idx5_reg;

    logic [C-1:0]     dax_reg, day_reg, dbx_reg, dby_reg;
    logic [SQ_W-1:0]  sax_reg, say_reg, sbx_reg, sby_reg;
    logic [D_W-1:0]   d1_reg, d2_reg;
    logic [D_W-1:0]   d5_reg;
    logic             flip5_reg;

    logic             found_reg;
    logic [D_W-1:0]   best_reg;
    logic [IDX_W-1:0] best_idx_reg;
    logic             best_flip_reg;

    logic [C-1:0]     ax, ay, bx, by;
    logic             take;
    logic             drained;

    function automatic logic [C-1:0] abs_diff(input logic [C-1:0] a, input logic [C-1:0] b);
        abs_diff = (a > b) ? (a - b) : (b - a);
    endfunction

    assign ax = rd_data[C-1:0];
    assign ay = rd_data[2*C-1:C];
    assign bx = rd_data[3*C-1:2*C];
    assign by = rd_data[4*C-1:3*C];

    assign rd_issue = running_reg && (ptr_reg < count);
    assign rd_addr  = ptr_reg[IDX_W-1:0];
    assign drained  = !(v1_reg || v2_reg || v3_reg || v4_reg || v5_reg);

    // with a forced first pick only the first unvisited entry is taken
    assign take = v5_reg && (!found_reg || (!force_reg && (d5_reg <= best_reg)));

    always_comb begin
        running_next = running_reg;
        if (cmd.go) begin
            running_next = 1'b1;
        end else if (running_reg && !rd_issue && drained) begin
            running_next = 1'b0;
        end
    end

    assign stat.done  = running_reg && !rd_issue && drained;
    assign stat.found = found_reg;
    assign stat.flip  = best_flip_reg;
    assign best_idx   = best_idx_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            running_reg <= 1'b0;
            ptr_reg     <= '0;
            force_reg   <= 1'b0;
            v1_reg      <= 1'b0;
            v2_reg      <= 1'b0;
            v3_reg      <= 1'b0;
            v4_reg      <= 1'b0;
            v5_reg      <= 1'b0;
            found_reg   <= 1'b0;
        end else begin
            running_reg <= running_next;
            if (cmd.go) begin
                ptr_reg   <= '0;
                force_reg <= cmd.force_first;
                found_reg <= 1'b0;
            end else begin
                if (rd_issue) begin
                    ptr_reg <= ptr_reg + CNT_W'(1);
                end
                if (take) begin
                    found_reg <= 1'b1;
                end
            end
            v1_reg <= rd_issue;
            v2_reg <= v1_reg && !rd_mark;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
        end
    end

    always_ff @(posedge aclk) begin
        idx1_reg  <= rd_addr;
        idx2_reg  <= idx1_reg;
        idx3_reg  <= idx2_reg;
        idx4_reg  <= idx3_reg;
        idx5_reg  <= idx4_reg;

        dax_reg   <= abs_diff(ax, cur_x);
        day_reg   <= abs_diff(ay, cur_y);
        dbx_reg   <= abs_diff(bx, cur_x);
        dby_reg   <= abs_diff(by, cur_y);

        sax_reg   <= SQ_W'(dax_reg) * SQ_W'(dax_reg);
        say_reg   <= SQ_W'(day_reg) * SQ_W'(day_reg);
        sbx_reg   <= SQ_W'(dbx_reg) * SQ_W'(dbx_reg);
        sby_reg   <= SQ_W'(dby_reg) * SQ_W'(dby_reg);

        d1_reg    <= D_W'(sax_reg) + D_W'(say_reg);
        d2_reg    <= D_W'(sbx_reg) + D_W'(sby_reg);

        d5_reg    <= (d1_reg < d2_reg) ? d1_reg : d2_reg;
        flip5_reg <= d2_reg < d1_reg;

        if (take) begin
            best_reg      <= d5_reg;
            best_idx_reg  <= idx5_reg;
            best_flip_reg <= flip5_reg;
        end
    end

endmodule

`default_nettype wire
